/* design/mrle_pkg.sv */
package mrle_pkg;

  localparam logic [1:0] CMD_IMAGE = 2'd0;
  localparam logic [1:0] CMD_BLOCK = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVERRUN = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;
  localparam logic [1:0] ST_PAST    = 2'd3;

  typedef struct packed {
    logic [7:0]  value;
    logic [15:0] count;
    logic        done;
    logic [1:0]  status;
  } run_t;

endpackage

/* design/marker_rle_2bpp_pixel_decoder.sv */
// Marker run-length decoder for 2-bit-per-pixel images.
// Input channel (in_valid_i / in_stall_o): one word per cycle unless
// stalled; command 0 starts an image, 1 starts a block (marker and
// unpacked length), 2 is a compressed data byte. Only completed runs
// and stray bytes give results. Output channel (out_valid_o /
// out_stall_i): one word per run with four color indices, repeat count,
// start column and bottom-up start row, block_done and status.
// A result passes the stage registers s1, s2 and out after the byte
// that ends the run is accepted; the position is split into column and
// row by a reciprocal multiply, a back multiply and one correction step.
// Throughput: one input word and one result per cycle unless stalled.
// Reset clears the parse state and position and empties the pipeline.
// When the receiver stalls, results queue in the three pipeline stages;
// in_stall_o rises only once all three hold a word, and follows
// out_stall_i in the same cycle.
module marker_rle_2bpp_pixel_decoder #(
  parameter int LINE_WIDTH = 320,
  parameter int LINE_COUNT = 200,
  parameter int COL_W      = $clog2(LINE_WIDTH),
  parameter int ROW_W      = $clog2(LINE_COUNT)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic [7:0]        block_marker_i,
  input  logic [15:0]       block_length_i,
  input  logic [7:0]        data_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        color_first_o,
  output logic [1:0]        color_second_o,
  output logic [1:0]        color_third_o,
  output logic [1:0]        color_fourth_o,
  output logic [15:0]       repeat_count_o,
  output logic [COL_W-1:0]  start_column_o,
  output logic [ROW_W-1:0]  start_row_o,
  output logic              block_done_o,
  output logic [1:0]        status_o
);
  import mrle_pkg::*;

  localparam int POS_W = $clog2(LINE_WIDTH * LINE_COUNT + 1);

  logic              ready;
  logic              accept;
  logic              emit;
  run_t              run;
  run_t              res;
  logic [POS_W-1:0]  pos;

  assign accept     = in_valid_i && ready;
  assign in_stall_o = !ready;

  mrle_parse #(
    .LINE_WIDTH (LINE_WIDTH),
    .LINE_COUNT (LINE_COUNT),
    .POS_W      (POS_W)
  ) u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .command_i      (command_i),
    .block_marker_i (block_marker_i),
    .block_length_i (block_length_i),
    .data_byte_i    (data_byte_i),
    .emit_o         (emit),
    .run_o          (run),
    .pos_o          (pos)
  );

  mrle_locate #(
    .LINE_WIDTH (LINE_WIDTH),
    .LINE_COUNT (LINE_COUNT),
    .POS_W      (POS_W),
    .COL_W      (COL_W),
    .ROW_W      (ROW_W)
  ) u_locate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept && emit),
    .ready_o (ready),
    .run_i   (run),
    .pos_i   (pos),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .run_o   (res),
    .col_o   (start_column_o),
    .row_o   (start_row_o)
  );

  assign color_first_o  = res.value[7:6];
  assign color_second_o = res.value[5:4];
  assign color_third_o  = res.value[3:2];
  assign color_fourth_o = res.value[1:0];
  assign repeat_count_o = res.count;
  assign block_done_o   = res.done;
  assign status_o       = res.status;

endmodule

/* design/mrle_parse.sv */
module mrle_parse #(
  parameter int LINE_WIDTH = 320,
  parameter int LINE_COUNT = 200,
  parameter int POS_W      = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        command_i,
  input  logic [7:0]        block_marker_i,
  input  logic [15:0]       block_length_i,
  input  logic [7:0]        data_byte_i,
  output logic              emit_o,
  output mrle_pkg::run_t    run_o,
  output logic [POS_W-1:0]  pos_o
);
  import mrle_pkg::*;

  localparam int IMAGE_END = LINE_WIDTH * LINE_COUNT;
  localparam int SUM_W     = ((POS_W > 18) ? POS_W : 18) + 1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COUNT,
    PH_WORD_LO,
    PH_WORD_HI,
    PH_VALUE
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [7:0]         marker_q, marker_d;
  logic [15:0]        left_q, left_d;
  logic               in_block_q, in_block_d;
  logic [15:0]        pend_q, pend_d;
  logic [POS_W-1:0]   pos_q, pos_d;

  logic               past;
  logic               over;
  logic               finish;
  logic [15:0]        fin_count;
  logic [15:0]        fin_left;
  logic [17:0]        pixels;
  logic [SUM_W-1:0]   pos_sum;
  logic [POS_W-1:0]   pos_fin;

  always_comb begin
    phase_d    = phase_q;
    marker_d   = marker_q;
    left_d     = left_q;
    in_block_d = in_block_q;
    pend_d     = pend_q;
    pos_d      = pos_q;
    emit_o     = 1'b0;
    finish     = 1'b0;

    past      = (pos_q >= POS_W'(IMAGE_END));
    fin_count = (phase_q == PH_IDLE) ? 16'd1 : pend_q;
    over      = (fin_count > left_q);
    fin_left  = over ? 16'd0 : (left_q - fin_count);
    pixels    = {fin_count, 2'b00};
    pos_sum   = SUM_W'(pos_q) + SUM_W'(pixels);
    pos_fin   = (past || (pos_sum >= SUM_W'(IMAGE_END))) ? POS_W'(IMAGE_END)
                                                         : POS_W'(pos_sum);

    run_o.value  = data_byte_i;
    run_o.count  = fin_count;
    run_o.done   = (fin_left == 16'd0);
    run_o.status = past ? ST_PAST : (over ? ST_OVERRUN : ST_OK);

    if (accept_i) begin
      unique case (command_i)
        CMD_IMAGE: begin
          phase_d    = PH_IDLE;
          marker_d   = 8'd0;
          left_d     = 16'd0;
          in_block_d = 1'b0;
          pend_d     = 16'd0;
          pos_d      = '0;
        end
        CMD_BLOCK: begin
          marker_d   = block_marker_i;
          left_d     = block_length_i;
          in_block_d = (block_length_i != 16'd0);
          phase_d    = PH_IDLE;
          pend_d     = 16'd0;
        end
        CMD_DATA: begin
          if (!in_block_q) begin
            emit_o       = 1'b1;
            run_o.count  = 16'd0;
            run_o.done   = 1'b0;
            run_o.status = past ? ST_PAST : ST_OUTSIDE;
          end else begin
            unique case (phase_q)
              PH_IDLE: begin
                if (data_byte_i == marker_q) begin
                  phase_d = PH_COUNT;
                end else begin
                  finish = 1'b1;
                end
              end
              PH_COUNT: begin
                if (data_byte_i != 8'd0) begin
                  pend_d  = {8'd0, data_byte_i};
                  phase_d = PH_VALUE;
                end else begin
                  phase_d = PH_WORD_LO;
                end
              end
              PH_WORD_LO: begin
                pend_d  = {8'd0, data_byte_i};
                phase_d = PH_WORD_HI;
              end
              PH_WORD_HI: begin
                pend_d  = {data_byte_i, pend_q[7:0]};
                phase_d = PH_VALUE;
              end
              PH_VALUE: begin
                finish = 1'b1;
              end
              default: begin
                phase_d = PH_IDLE;
              end
            endcase
          end
        end
        default: ;
      endcase
    end

    if (finish) begin
      emit_o  = 1'b1;
      left_d  = fin_left;
      pos_d   = pos_fin;
      phase_d = PH_IDLE;
      pend_d  = 16'd0;
      if (fin_left == 16'd0) begin
        in_block_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      marker_q   <= 8'd0;
      left_q     <= 16'd0;
      in_block_q <= 1'b0;
      pend_q     <= 16'd0;
      pos_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      marker_q   <= marker_d;
      left_q     <= left_d;
      in_block_q <= in_block_d;
      pend_q     <= pend_d;
      pos_q      <= pos_d;
    end
  end

  // start position of the run
  assign pos_o = pos_q;

endmodule

/* design/mrle_locate.sv */
module mrle_locate #(
  parameter int LINE_WIDTH = 320,
  parameter int LINE_COUNT = 200,
  parameter int POS_W      = 16,
  parameter int COL_W      = 9,
  parameter int ROW_W      = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  mrle_pkg::run_t    run_i,
  input  logic [POS_W-1:0]  pos_i,
  output logic              valid_o,
  input  logic              stall_i,
  output mrle_pkg::run_t    run_o,
  output logic [COL_W-1:0]  col_o,
  output logic [ROW_W-1:0]  row_o
);
  import mrle_pkg::*;

  // q0 = floor(pos * floor(2^POS_W / W) / 2^POS_W) is q or q - 1
  localparam int RECIP = (2 ** POS_W) / LINE_WIDTH;
  localparam int RCP_W = $clog2(RECIP + 1);
  localparam int MUL_W = POS_W + RCP_W;
  localparam int Q_W   = $clog2(LINE_COUNT + 1);
  localparam int QW_W  = Q_W + $clog2(LINE_WIDTH + 1);

  logic               adv_out, adv2, adv1;

  logic               s1_v_q;
  run_t               s1_run_q;
  logic [POS_W-1:0]   s1_pos_q;
  logic [MUL_W-1:0]   s1_prod_q, s1_prod_d;

  logic               s2_v_q;
  run_t               s2_run_q;
  logic [POS_W-1:0]   s2_pos_q;
  logic [Q_W-1:0]     s2_q0_q, s2_q0_d;
  logic [POS_W-1:0]   s2_qw_q, s2_qw_d;
  logic [QW_W-1:0]    qw_full;

  logic               out_v_q;
  run_t               out_run_q;
  logic [COL_W-1:0]   out_col_q, out_col_d;
  logic [ROW_W-1:0]   out_row_q, out_row_d;
  logic [POS_W-1:0]   rem;
  logic               fix;
  logic [Q_W-1:0]     quo;

  assign adv_out = !out_v_q || !stall_i;
  assign adv2    = !s2_v_q || adv_out;
  assign adv1    = !s1_v_q || adv2;
  assign ready_o = adv1;

  always_comb begin
    s1_prod_d = {{RCP_W{1'b0}}, pos_i} * MUL_W'(RECIP);
    s2_q0_d   = Q_W'(s1_prod_q[MUL_W-1:POS_W]);
    qw_full   = QW_W'(s2_q0_d) * QW_W'(LINE_WIDTH);
    s2_qw_d   = POS_W'(qw_full);
    rem       = s2_pos_q - s2_qw_q;
    fix       = (rem >= POS_W'(LINE_WIDTH));
    quo       = s2_q0_q + Q_W'(fix);
    if (s2_run_q.status == ST_PAST) begin
      out_col_d = '0;
      out_row_d = '0;
    end else begin
      out_col_d = fix ? COL_W'(rem - POS_W'(LINE_WIDTH)) : COL_W'(rem);
      out_row_d = ROW_W'(LINE_COUNT - 1) - quo[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_v_q <= valid_i;
      end
      if (adv2) begin
        s2_v_q <= s1_v_q;
      end
      if (adv_out) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_run_q  <= run_i;
      s1_pos_q  <= pos_i;
      s1_prod_q <= s1_prod_d;
    end
    if (adv2) begin
      s2_run_q <= s1_run_q;
      s2_pos_q <= s1_pos_q;
      s2_q0_q  <= s2_q0_d;
      s2_qw_q  <= s2_qw_d;
    end
    if (adv_out) begin
      out_run_q <= s2_run_q;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  assign valid_o = out_v_q;
  assign run_o   = out_run_q;
  assign col_o   = out_col_q;
  assign row_o   = out_row_q;

  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv1 |-> (s1_v_q && s2_v_q && out_v_q))
    else $error("input held off with a free stage");

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !adv2) |=> s1_v_q)
    else $error("stage one word lost");

  a_one_fix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> ({1'b0, s2_pos_q - s2_qw_q} < (POS_W + 1)'(2 * LINE_WIDTH)))
    else $error("quotient estimate off by more than one");

  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_run_q.status != ST_PAST)) |->
      (int'(out_col_q) < LINE_WIDTH))
    else $error("column out of range");

endmodule
